// File: rtl/ec2d_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the two-body elastic collision block
package ec2d_pkg;

  // pipelined restoring divider: numerator, divisor and quotient widths
  localparam int DIV_NUM_W = 63;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_QB    = 35;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // normalised separation magnitude width, range [2^29, 2^30)
  localparam int NORM_W = 30;

  typedef struct packed {
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
  } ec2d_vel_t;

  // one classified request as handed from front to back
  typedef struct packed {
    logic [NORM_W-1:0]  ax;
    logic [NORM_W-1:0]  ay;
    logic               nx;
    logic               ny;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
    ec2d_vel_t          vel;
    logic [31:0]        m1;
    logic [31:0]        m2;
    logic               deg;
  } ec2d_item_t;

endpackage

// File: rtl/ec2d_div.sv
`timescale 1ns / 1ps
// fully pipelined restoring divider, one quotient bit per stage
module ec2d_div
  import ec2d_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_QB-1:0]    quo
);

  logic [DIV_DEN_W-1:0] rem_r [DIV_QB];
  logic [DIV_QB-1:0]    nb_r  [DIV_QB];
  logic [DIV_QB-1:0]    qt_r  [DIV_QB];
  logic [DIV_DEN_W-1:0] dv_r  [DIV_QB];

  for (genvar i = 0; i < DIV_QB; i++) begin : g_stage
    logic [DIV_DEN_W-1:0] rin;
    logic [DIV_DEN_W-1:0] din;
    logic [DIV_QB-1:0]    nin;
    logic [DIV_QB-1:0]    qin;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    if (i == 0) begin : g_first
      // top bits of the numerator form the starting remainder
      assign rin = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_QB]);
      assign nin = num[DIV_QB-1:0];
      assign qin = '0;
      assign din = den;
    end else begin : g_next
      assign rin = rem_r[i-1];
      assign nin = nb_r[i-1];
      assign qin = qt_r[i-1];
      assign din = dv_r[i-1];
    end

    assign trial = {rin, nin[DIV_QB-1]};
    assign ge    = trial >= {1'b0, din};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? DIV_DEN_W'(trial - {1'b0, din}) : trial[DIV_DEN_W-1:0];
        nb_r[i]  <= {nin[DIV_QB-2:0], 1'b0};
        qt_r[i]  <= {qin[DIV_QB-2:0], ge};
        dv_r[i]  <= din;
      end
    end
  end

  assign quo = qt_r[DIV_QB-1];

endmodule

// File: rtl/ec2d_front.sv
`timescale 1ns / 1ps
// front end: takes requests, forms centre differences and normalises them
module ec2d_front
  import ec2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_valid,
  output logic               pair_stall,
  input  logic signed [31:0] first_x,
  input  logic signed [31:0] first_y,
  input  logic signed [31:0] second_x,
  input  logic signed [31:0] second_y,
  input  logic signed [31:0] first_vel_x,
  input  logic signed [31:0] first_vel_y,
  input  logic signed [31:0] second_vel_x,
  input  logic signed [31:0] second_vel_y,
  input  logic [31:0]        first_mass,
  input  logic [31:0]        second_mass,
  input  logic               q_full,
  output logic               push,
  output ec2d_item_t         push_item
);

  logic en;

  // stage 1: differences and magnitudes
  logic               f1_vld;
  logic [32:0]        f1_ax, f1_ay;
  logic               f1_nx, f1_ny;
  logic signed [32:0] f1_dvx, f1_dvy;
  ec2d_vel_t          f1_vel;
  logic [31:0]        f1_m1, f1_m2;

  // stage 2: leading one search
  logic               f2_vld;
  logic [32:0]        f2_ax, f2_ay;
  logic               f2_nx, f2_ny;
  logic signed [32:0] f2_dvx, f2_dvy;
  ec2d_vel_t          f2_vel;
  logic [31:0]        f2_m1, f2_m2;
  logic [5:0]         f2_lsh;
  logic               f2_deg;

  // stage 3: shifted item ready for the queue
  logic               f3_vld;
  ec2d_item_t         f3_item;

  logic signed [32:0] dx, dy;
  logic [32:0]        or33;
  logic [5:0]         msb;
  logic [64:0]        shx, shy;

  assign en         = !(f3_vld && q_full);
  assign pair_stall = !en;
  assign push       = f3_vld && !q_full;
  assign push_item  = f3_item;

  assign dx = {second_x[31], second_x} - {first_x[31], first_x};
  assign dy = {second_y[31], second_y} - {first_y[31], first_y};

  assign or33 = f1_ax | f1_ay;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 33; i++) begin
      if (or33[i]) msb = 6'(i);
    end
  end

  assign shx = {32'd0, f2_ax} << f2_lsh;
  assign shy = {32'd0, f2_ay} << f2_lsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      f3_vld <= 1'b0;
    end else if (en) begin
      f1_vld <= pair_valid;
      f2_vld <= f1_vld;
      f3_vld <= f2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_nx      <= dx[32];
      f1_ny      <= dy[32];
      f1_ax      <= dx[32] ? 33'(-dx) : dx;
      f1_ay      <= dy[32] ? 33'(-dy) : dy;
      f1_dvx     <= {second_vel_x[31], second_vel_x} - {first_vel_x[31], first_vel_x};
      f1_dvy     <= {second_vel_y[31], second_vel_y} - {first_vel_y[31], first_vel_y};
      f1_vel.v1x <= first_vel_x;
      f1_vel.v1y <= first_vel_y;
      f1_vel.v2x <= second_vel_x;
      f1_vel.v2y <= second_vel_y;
      f1_m1      <= first_mass;
      f1_m2      <= second_mass;

      f2_ax  <= f1_ax;
      f2_ay  <= f1_ay;
      f2_nx  <= f1_nx;
      f2_ny  <= f1_ny;
      f2_dvx <= f1_dvx;
      f2_dvy <= f1_dvy;
      f2_vel <= f1_vel;
      f2_m1  <= f1_m1;
      f2_m2  <= f1_m2;
      f2_lsh <= 6'd32 - msb;
      f2_deg <= or33 == '0;

      // leading one lands on bit 32, keep bits 32..3
      f3_item.ax  <= shx[32:3];
      f3_item.ay  <= shy[32:3];
      f3_item.nx  <= f2_nx;
      f3_item.ny  <= f2_ny;
      f3_item.dvx <= f2_dvx;
      f3_item.dvy <= f2_dvy;
      f3_item.vel <= f2_vel;
      f3_item.m1  <= f2_m1;
      f3_item.m2  <= f2_m2;
      f3_item.deg <= f2_deg;
    end
  end

endmodule

// File: rtl/ec2d_fifo.sv
`timescale 1ns / 1ps
// short queue decoupling the front end from the arithmetic back end
module ec2d_fifo
  import ec2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ec2d_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output ec2d_item_t head
);

  ec2d_item_t         mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW:0]   cnt, cnt_next;

  assign full  = cnt == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign empty = cnt == '0;
  assign head  = mem[rptr];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_next = cnt + 1'b1;
      2'b01:   cnt_next = cnt - 1'b1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

endmodule

// File: rtl/ec2d_back.sv
`timescale 1ns / 1ps
// back end: projection, division, mass weighting and saturation pipeline
module ec2d_back
  import ec2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  ec2d_item_t         q_head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] new_first_vel_x,
  output logic signed [31:0] new_first_vel_y,
  output logic signed [31:0] new_second_vel_x,
  output logic signed [31:0] new_second_vel_y,
  output logic               degenerate
);

  typedef struct packed {
    logic [NORM_W-1:0] ax;
    logic [NORM_W-1:0] ay;
    logic              nx;
    logic              ny;
    logic              pneg;
    logic              totz;
    ec2d_vel_t         vel;
    logic              deg;
  } dl_t;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] s);
    logic signed [31:0] r;
    if (s > 37'sd2147483647) r = 32'sh7fff_ffff;
    else if (s < -37'sd2147483648) r = 32'sh8000_0000;
    else r = s[31:0];
    return r;
  endfunction

  logic en;

  logic               s1_vld;
  ec2d_item_t         s1_it;
  logic signed [63:0] s1_tx, s1_ty;
  logic [59:0]        s1_sqx, s1_sqy;
  logic [32:0]        s1_tot;

  logic               s2_vld;
  ec2d_item_t         s2_it;
  logic signed [63:0] s2_p;
  logic [31:0]        s2_ds;
  logic [32:0]        s2_tot;

  logic               s3_vld;
  ec2d_item_t         s3_it;
  logic [34:0]        s3_pm;
  logic               s3_pneg;
  logic [31:0]        s3_ds;
  logic [32:0]        s3_tot;

  logic               dl_vld [DIV_QB];
  dl_t                dl     [DIV_QB];

  logic [DIV_QB-1:0]  quo_q, quo_f1, quo_f2;

  logic               s4_vld;
  logic [32:0]        s4_wx, s4_wy;
  logic [31:0]        s4_f1, s4_f2;
  logic               s4_wxneg, s4_wyneg;
  ec2d_vel_t          s4_vel;
  logic               s4_deg;

  logic               s5_vld;
  logic [34:0]        s5_e1x, s5_e1y, s5_e2x, s5_e2y;
  logic               s5_wxneg, s5_wyneg;
  ec2d_vel_t          s5_vel;
  logic               s5_deg;

  logic signed [63:0] ptx, pty;
  logic [60:0]        d2;
  logic [63:0]        pmag;
  logic [64:0]        prx, pry;
  logic [36:0]        wxf, wyf;
  logic [64:0]        p1x, p1y, p2x, p2y;
  logic [36:0]        r1x, r1y, r2x, r2y;

  assign en  = !(result_valid && result_stall);
  assign pop = en && !q_empty;

  assign ptx  = s1_it.nx ? -s1_tx : s1_tx;
  assign pty  = s1_it.ny ? -s1_ty : s1_ty;
  assign d2   = {1'b0, s1_sqx} + {1'b0, s1_sqy};
  assign pmag = s2_p[63] ? 64'(-s2_p) : 64'(s2_p);

  ec2d_div u_div_q (
    .clk (clk),
    .en  (en),
    .num ({s3_pm, 28'd0}),
    .den ({1'b0, s3_ds}),
    .quo (quo_q)
  );

  ec2d_div u_div_f1 (
    .clk (clk),
    .en  (en),
    .num ({s3_it.m2, 31'd0}),
    .den (s3_tot),
    .quo (quo_f1)
  );

  ec2d_div u_div_f2 (
    .clk (clk),
    .en  (en),
    .num ({s3_it.m1, 31'd0}),
    .den (s3_tot),
    .quo (quo_f2)
  );

  assign prx = dl[DIV_QB-1].ax * quo_q;
  assign pry = dl[DIV_QB-1].ay * quo_q;
  assign wxf = prx[64:28];
  assign wyf = pry[64:28];

  assign p1x = s4_f1 * s4_wx;
  assign p1y = s4_f1 * s4_wy;
  assign p2x = s4_f2 * s4_wx;
  assign p2y = s4_f2 * s4_wy;

  // velocity updates in 37 bits before saturation
  assign r1x = s5_wxneg ? {{5{s5_vel.v1x[31]}}, s5_vel.v1x} - {2'b00, s5_e1x}
                        : {{5{s5_vel.v1x[31]}}, s5_vel.v1x} + {2'b00, s5_e1x};
  assign r1y = s5_wyneg ? {{5{s5_vel.v1y[31]}}, s5_vel.v1y} - {2'b00, s5_e1y}
                        : {{5{s5_vel.v1y[31]}}, s5_vel.v1y} + {2'b00, s5_e1y};
  assign r2x = s5_wxneg ? {{5{s5_vel.v2x[31]}}, s5_vel.v2x} + {2'b00, s5_e2x}
                        : {{5{s5_vel.v2x[31]}}, s5_vel.v2x} - {2'b00, s5_e2x};
  assign r2y = s5_wyneg ? {{5{s5_vel.v2y[31]}}, s5_vel.v2y} + {2'b00, s5_e2y}
                        : {{5{s5_vel.v2y[31]}}, s5_vel.v2y} - {2'b00, s5_e2y};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld       <= 1'b0;
      s2_vld       <= 1'b0;
      s3_vld       <= 1'b0;
      s4_vld       <= 1'b0;
      s5_vld       <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < DIV_QB; i++) dl_vld[i] <= 1'b0;
    end else if (en) begin
      s1_vld    <= !q_empty;
      s2_vld    <= s1_vld;
      s3_vld    <= s2_vld;
      dl_vld[0] <= s3_vld;
      for (int i = 1; i < DIV_QB; i++) dl_vld[i] <= dl_vld[i-1];
      s4_vld       <= dl_vld[DIV_QB-1];
      s5_vld       <= s4_vld;
      result_valid <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_it  <= q_head;
      s1_tx  <= $signed({1'b0, q_head.ax}) * $signed(q_head.dvx);
      s1_ty  <= $signed({1'b0, q_head.ay}) * $signed(q_head.dvy);
      s1_sqx <= q_head.ax * q_head.ax;
      s1_sqy <= q_head.ay * q_head.ay;
      s1_tot <= {1'b0, q_head.m1} + {1'b0, q_head.m2};

      s2_it  <= s1_it;
      s2_p   <= ptx + pty;
      s2_ds  <= d2[60:29];
      s2_tot <= s1_tot;

      s3_it   <= s2_it;
      s3_pm   <= pmag[63:29];
      s3_pneg <= s2_p[63];
      s3_ds   <= s2_ds;
      s3_tot  <= s2_tot;

      dl[0].ax   <= s3_it.ax;
      dl[0].ay   <= s3_it.ay;
      dl[0].nx   <= s3_it.nx;
      dl[0].ny   <= s3_it.ny;
      dl[0].pneg <= s3_pneg;
      dl[0].totz <= s3_tot == '0;
      dl[0].vel  <= s3_it.vel;
      dl[0].deg  <= s3_it.deg;
      for (int i = 1; i < DIV_QB; i++) dl[i] <= dl[i-1];

      s4_wx    <= (wxf > 37'h1_ffff_ffff) ? 33'h1_ffff_ffff : wxf[32:0];
      s4_wy    <= (wyf > 37'h1_ffff_ffff) ? 33'h1_ffff_ffff : wyf[32:0];
      s4_f1    <= dl[DIV_QB-1].totz ? 32'h4000_0000 : quo_f1[31:0];
      s4_f2    <= dl[DIV_QB-1].totz ? 32'h4000_0000 : quo_f2[31:0];
      s4_wxneg <= dl[DIV_QB-1].nx ^ dl[DIV_QB-1].pneg;
      s4_wyneg <= dl[DIV_QB-1].ny ^ dl[DIV_QB-1].pneg;
      s4_vel   <= dl[DIV_QB-1].vel;
      s4_deg   <= dl[DIV_QB-1].deg;

      s5_e1x   <= p1x[64:30];
      s5_e1y   <= p1y[64:30];
      s5_e2x   <= p2x[64:30];
      s5_e2y   <= p2y[64:30];
      s5_wxneg <= s4_wxneg;
      s5_wyneg <= s4_wyneg;
      s5_vel   <= s4_vel;
      s5_deg   <= s4_deg;

      new_first_vel_x  <= s5_deg ? s5_vel.v1x : sat32($signed(r1x));
      new_first_vel_y  <= s5_deg ? s5_vel.v1y : sat32($signed(r1y));
      new_second_vel_x <= s5_deg ? s5_vel.v2x : sat32($signed(r2x));
      new_second_vel_y <= s5_deg ? s5_vel.v2y : sat32($signed(r2y));
      degenerate       <= s5_deg;
    end
  end

endmodule

// File: rtl/elastic_collision_2d.sv
`timescale 1ns / 1ps
// top level of the two-body elastic collision block
//
// Takes one colliding pair of circles per request (both centres, both
// velocities, both masses, all Q16.16) and returns both velocities after an
// elastic collision: the components along the centre-to-centre normal are
// exchanged by the mass-weighted one-dimensional formula, the tangential
// components are kept, and every result saturates to the signed 32-bit range.
// Coincident centres pass the velocities through unchanged with degenerate
// set. A new request is taken every clock cycle while pair_stall is low, and
// the path from request to result is dominated by the 35-stage pipelined
// dividers that form the projection quotient and the two mass factors. The
// front end (three stages: centre differences,
// leading-one search, normalising shift) feeds a four-entry queue, and the
// back end drains it through its multiply and divide pipeline into an output
// register; a stall on the result side freezes the back end only, while the
// front keeps taking requests until the queue fills. pair_stall depends on
// registered state only. There is no configuration and no state carried
// between requests.
module elastic_collision_2d
  import ec2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_valid,
  output logic               pair_stall,
  input  logic signed [31:0] first_x,
  input  logic signed [31:0] first_y,
  input  logic signed [31:0] second_x,
  input  logic signed [31:0] second_y,
  input  logic signed [31:0] first_vel_x,
  input  logic signed [31:0] first_vel_y,
  input  logic signed [31:0] second_vel_x,
  input  logic signed [31:0] second_vel_y,
  input  logic [31:0]        first_mass,
  input  logic [31:0]        second_mass,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] new_first_vel_x,
  output logic signed [31:0] new_first_vel_y,
  output logic signed [31:0] new_second_vel_x,
  output logic signed [31:0] new_second_vel_y,
  output logic               degenerate
);

  // front to queue
  logic       q_full;
  logic       push;
  ec2d_item_t push_item;

  // queue to back
  logic       q_empty;
  logic       pop;
  ec2d_item_t q_head;

  ec2d_front u_front (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .first_x      (first_x),
    .first_y      (first_y),
    .second_x     (second_x),
    .second_y     (second_y),
    .first_vel_x  (first_vel_x),
    .first_vel_y  (first_vel_y),
    .second_vel_x (second_vel_x),
    .second_vel_y (second_vel_y),
    .first_mass   (first_mass),
    .second_mass  (second_mass),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  // holds classified requests while the back end is stalled
  ec2d_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ec2d_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .pop              (pop),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .new_first_vel_x  (new_first_vel_x),
    .new_first_vel_y  (new_first_vel_y),
    .new_second_vel_x (new_second_vel_x),
    .new_second_vel_y (new_second_vel_y),
    .degenerate       (degenerate)
  );

endmodule

// File: rtl/ec2d_checker.sv
`timescale 1ns / 1ps
// port-level checks for the elastic collision block, bound to the top level
module ec2d_checker (
  input logic               clk,
  input logic               rst,
  input logic               pair_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [31:0] new_first_vel_x,
  input logic signed [31:0] new_first_vel_y,
  input logic signed [31:0] new_second_vel_x,
  input logic signed [31:0] new_second_vel_y,
  input logic               degenerate
);

  // pipeline empties on reset
  a_rst_result: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid straight after reset");

  // front end is free to take a request straight after reset
  a_rst_stall: assert property (@(posedge clk) rst |=> !pair_stall)
    else $error("request side stalled straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(new_first_vel_x) &&
      $stable(new_first_vel_y) && $stable(new_second_vel_x) &&
      $stable(new_second_vel_y) && $stable(degenerate))
    else $error("stalled result changed");

endmodule

bind elastic_collision_2d ec2d_checker u_ec2d_checker (.*);
